### design/ght_pkg.sv
// Shared types and constants for the generational handle table.
// No dependencies; ght_if, ght_exec and the top module import this package.
package ght_pkg;

  typedef enum logic [1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_GET   = 2'd2,
    FUNC_SET   = 2'd3
  } func_t;

  // XOR mask applied to every handle crossing the ports
  localparam logic [63:0] HANDLE_KEY = 64'h7f94a11ab7b3ee6b;
  // Multiplier between consecutive fresh-slot generations
  localparam logic [31:0] GEN_MULT   = 32'd6269629;

  typedef struct packed {
    logic        ok;
    logic [63:0] handle_out;
    logic [63:0] data_out;
  } rsp_t;

endpackage

### design/ght_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on ght_pkg for the function code type.
interface ght_req_if import ght_pkg::*; ();
  logic        valid;
  logic        ready;
  func_t       func;
  logic [63:0] handle;
  logic [63:0] data_in;

  modport source (output valid, output func, output handle, output data_in, input ready);
  modport sink   (input valid, input func, input handle, input data_in, output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        ok;
  logic [63:0] handle_out;
  logic [63:0] data_out;

  modport source (output valid, output ok, output handle_out, output data_out, input ready);
  modport sink   (input valid, input ok, input handle_out, input data_out, output ready);
endinterface

### design/ght_slot_mem.sv
// Slot storage: one write port, one read port with registered read data.
// Standalone; entry layout is defined by the users of the word.
module ght_slot_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 108
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ght_exec.sv
// Request evaluation: checks a handle against the slot word read for it,
// builds the response and the slot write-back. Depends on ght_pkg.
module ght_exec import ght_pkg::*; #(
  parameter int ENTRIES = 1024
) (
  input  func_t                          func,
  input  logic [$clog2(ENTRIES)-1:0]     idx,
  input  logic [31:0]                    gen,
  input  logic                           range_ok,
  input  logic [63:0]                    data_in,
  input  logic [64+32+1+$clog2(ENTRIES+1)-1:0] slot,
  input  logic [$clog2(ENTRIES+1)-1:0]   free_head,
  input  logic [$clog2(ENTRIES+1)-1:0]   fresh_count,
  input  logic                           page_first,
  input  logic [31:0]                    gen_seed,
  input  logic [31:0]                    fresh_gen,
  output rsp_t                           rsp,
  output logic                           wr_en,
  output logic [$clog2(ENTRIES)-1:0]     wr_addr,
  output logic [64+32+1+$clog2(ENTRIES+1)-1:0] wr_data,
  output logic [$clog2(ENTRIES+1)-1:0]   free_head_next,
  output logic                           fresh_take,
  output logic [31:0]                    fresh_gen_next
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] EMPTY = LW'(ENTRIES);

  logic [63:0]   s_data;
  logic [31:0]   s_gen;
  logic          s_use;
  logic [LW-1:0] s_link;
  logic [31:0]   fresh_g;
  logic [31:0]   a_gen;
  logic          hit;

  assign s_data = slot[LW+96:LW+33];
  assign s_gen  = slot[LW+32:LW+1];
  assign s_use  = slot[LW];
  assign s_link = slot[LW-1:0];

  assign fresh_g        = page_first ? gen_seed : fresh_gen;
  assign fresh_gen_next = fresh_g * GEN_MULT;
  assign hit            = range_ok && s_use && (s_gen == gen);

  always_comb begin
    rsp            = '0;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = slot;
    free_head_next = free_head;
    fresh_take     = 1'b0;
    a_gen          = s_gen;
    case (func)
      FUNC_ALLOC: begin
        if (free_head != EMPTY) begin
          // reuse the most recently freed slot
          wr_addr        = free_head[IW-1:0];
          free_head_next = s_link;
          rsp.ok         = 1'b1;
        end else if (fresh_count != EMPTY) begin
          wr_addr    = fresh_count[IW-1:0];
          a_gen      = fresh_g;
          fresh_take = 1'b1;
          rsp.ok     = 1'b1;
        end
        if (rsp.ok) begin
          wr_en          = 1'b1;
          wr_data        = {64'd0, a_gen, 1'b1, EMPTY};
          rsp.handle_out = {a_gen, 32'(wr_addr)} ^ HANDLE_KEY;
        end
      end
      FUNC_FREE: begin
        if (hit) begin
          wr_en          = 1'b1;
          wr_data        = {s_data, s_gen + 32'd1, 1'b0, free_head};
          free_head_next = LW'(idx);
          rsp.ok         = 1'b1;
        end
      end
      FUNC_GET: begin
        if (hit) begin
          rsp.ok       = 1'b1;
          rsp.data_out = s_data;
        end
      end
      FUNC_SET: begin
        if (hit) begin
          wr_en   = 1'b1;
          wr_data = {data_in, s_gen, 1'b1, s_link};
          rsp.ok  = 1'b1;
        end
      end
      default: begin
        rsp.ok = 1'b0;
      end
    endcase
  end

endmodule

### design/generational_handle_table.sv
// Generational handle table: a request is accepted in IDLE, where the slot memory
// read is issued, and evaluated in EXEC, where the slot is written back and the
// response is registered; no new request is taken until EXEC finishes.
// A response that is not taken holds the execute cycle until rsp.ready.
// Reset (rst, synchronous) empties the free list, clears the fresh counter,
// page position and gen_seed; the slot memory is not cleared.
module generational_handle_table import ght_pkg::*; #(
  parameter int ENTRIES    = 1024,
  parameter int PAGE_SLOTS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  ght_req_if.sink     req,
  ght_rsp_if.source   rsp
);

  localparam int IW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam int PW = $clog2(PAGE_SLOTS);
  localparam int SW = 64 + 32 + 1 + LW;
  localparam logic [LW-1:0] EMPTY     = LW'(ENTRIES);
  localparam logic [PW-1:0] PAGE_LAST = PW'(PAGE_SLOTS - 1);

  // Request sequencer: IDLE takes a beat, EXEC evaluates and writes back
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t        state;
  logic          req_fire;
  logic          done;

  // Configuration and table bookkeeping
  logic [31:0]   gen_seed;
  logic [LW-1:0] free_head;
  logic [LW-1:0] fresh_count;
  logic [PW-1:0] page_pos;
  logic [31:0]   fresh_gen;

  // Decoded request, captured on the accepting beat
  logic [63:0]   raw;
  logic [31:0]   raw_idx;
  logic [IW-1:0] raddr;
  func_t         func_q;
  logic [IW-1:0] idx_q;
  logic [31:0]   gen_q;
  logic          range_ok_q;
  logic [63:0]   data_q;

  // Slot memory and evaluation results
  logic [SW-1:0] slot;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [SW-1:0] wr_data;
  logic [LW-1:0] free_head_next;
  logic          fresh_take;
  logic [31:0]   fresh_gen_next;
  rsp_t          rsp_next;
  rsp_t          rsp_q;
  logic          rsp_valid;

  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  // Finish the execute cycle only once the response register is free
  assign done      = (state == ST_EXEC) && (!rsp_valid || rsp.ready);

  // Strip the key; the upper half is the generation, the lower the index
  assign raw     = req.handle ^ HANDLE_KEY;
  assign raw_idx = raw[31:0];
  // Allocate looks at the free-list head slot to learn its link and generation
  assign raddr   = (req.func == FUNC_ALLOC) ? free_head[IW-1:0] : raw_idx[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_fire) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (done) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Capture the request; fresh_count cannot change before EXEC uses range_ok_q
  always_ff @(posedge clk) begin
    if (req_fire) begin
      func_q     <= req.func;
      idx_q      <= raw_idx[IW-1:0];
      gen_q      <= raw[63:32];
      range_ok_q <= (raw_idx < 32'(fresh_count));
      data_q     <= req.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_seed <= 32'd0;
    end else if (cfg_we) begin
      gen_seed <= cfg_wdata;
    end
  end

  // Free list head, fresh index and the running fresh generation
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head   <= EMPTY;
      fresh_count <= '0;
      page_pos    <= '0;
      fresh_gen   <= 32'd0;
    end else if (done) begin
      free_head <= free_head_next;
      if (fresh_take) begin
        fresh_count <= fresh_count + LW'(1);
        fresh_gen   <= fresh_gen_next;
        page_pos    <= (page_pos == PAGE_LAST) ? '0 : page_pos + PW'(1);
      end
    end
  end

  ght_slot_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (SW)
  ) u_mem (
    .clk   (clk),
    .we    (done && wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (req_fire),
    .raddr (raddr),
    .rdata (slot)
  );

  ght_exec #(
    .ENTRIES (ENTRIES)
  ) u_exec (
    .func           (func_q),
    .idx            (idx_q),
    .gen            (gen_q),
    .range_ok       (range_ok_q),
    .data_in        (data_q),
    .slot           (slot),
    .free_head      (free_head),
    .fresh_count    (fresh_count),
    .page_first     (page_pos == '0),
    .gen_seed       (gen_seed),
    .fresh_gen      (fresh_gen),
    .rsp            (rsp_next),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .free_head_next (free_head_next),
    .fresh_take     (fresh_take),
    .fresh_gen_next (fresh_gen_next)
  );

  // Response register: load on finish, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.ok         = rsp_q.ok;
  assign rsp.handle_out = rsp_q.handle_out;
  assign rsp.data_out   = rsp_q.data_out;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for generational_handle_table: drives request beats, predicts
// each response from a local copy of the slot map and compares field by field.
// Depends on ght_pkg, the ght_req_if / ght_rsp_if interfaces and the design top.
module testbench;
  import ght_pkg::*;

  localparam int ENTRIES    = 1024;
  localparam int PAGE_SLOTS = 256;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  ght_req_if req_ch ();
  ght_rsp_if rsp_ch ();

  generational_handle_table #(
    .ENTRIES   (ENTRIES),
    .PAGE_SLOTS(PAGE_SLOTS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Local slot map: mirrors the table state as of the last accepted request
  // ---------------------------------------------------------------------------
  logic [63:0] slot_word [ENTRIES];
  logic [31:0] slot_gen  [ENTRIES];
  bit          slot_live [ENTRIES];
  int unsigned slot_next [ENTRIES];
  int unsigned free_top       = ENTRIES;  // ENTRIES marks an empty free list
  int unsigned issued         = 0;        // fresh slots handed out so far
  logic [31:0] next_fresh_gen = '0;
  logic [31:0] seed_reg       = '0;

  rsp_t        pending_rsp [$];           // responses owed by the design, oldest first
  rsp_t        last_rsp;                  // prediction for the most recent beat
  int unsigned mismatches = 0;

  // Idle percentages for each side, and the long receiver hold-off
  int unsigned req_gap_pct = 0;
  int unsigned rsp_gap_pct = 0;
  int unsigned hold_left   = 0;

  function automatic logic [63:0] make_handle(logic [31:0] g, int unsigned i);
    return {g, 32'(i)} ^ HANDLE_KEY;
  endfunction

  // Advance the local slot map by one request and queue the response it owes.
  task automatic slot_map_step(func_t f, logic [63:0] h, logic [63:0] d);
    rsp_t        r;
    logic [63:0] raw;
    int unsigned i;
    logic [31:0] g;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    if (f == FUNC_ALLOC) begin
      if (free_top < ENTRIES) begin
        // LIFO: reuse the most recently freed slot
        i        = free_top;
        free_top = slot_next[i];
        hit      = 1'b1;
      end else if (issued < ENTRIES) begin
        // Fresh slot: restart the generation chain at every page boundary
        i              = issued;
        g              = (i % PAGE_SLOTS == 0) ? seed_reg : next_fresh_gen;
        slot_gen[i]    = g;
        next_fresh_gen = g * GEN_MULT;
        issued++;
        hit = 1'b1;
      end
      if (hit) begin
        slot_live[i]  = 1'b1;
        slot_next[i]  = ENTRIES;
        slot_word[i]  = '0;
        r.ok          = 1'b1;
        r.handle_out  = make_handle(slot_gen[i], i);
      end
    end else begin
      raw = h ^ HANDLE_KEY;
      i   = raw[31:0];
      g   = raw[63:32];
      // Unissued index, slot not in use, or stale generation: plain failure
      if (i < issued && slot_live[i] && slot_gen[i] == g) begin
        r.ok = 1'b1;
        case (f)
          FUNC_FREE: begin
            slot_gen[i]  = slot_gen[i] + 32'd1;
            slot_live[i] = 1'b0;
            slot_next[i] = free_top;
            free_top     = i;
          end
          FUNC_GET: begin
            r.data_out = slot_word[i];
          end
          default: begin
            slot_word[i] = d;
          end
        endcase
      end
    end
    pending_rsp.push_back(r);
    last_rsp = r;
  endtask

  // Find a live slot, starting the scan at a random index.
  function automatic bit pick_live(output logic [63:0] h);
    int unsigned start;
    int unsigned i;
    h     = '0;
    start = $urandom_range(ENTRIES - 1);
    for (int k = 0; k < ENTRIES; k++) begin
      i = (start + k) % ENTRIES;
      if (i < issued && slot_live[i]) begin
        h = make_handle(slot_gen[i], i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------------

  // Offer one request beat; return at the edge that accepts it. The caller must
  // be sitting on a rising edge, so valid gets exactly one assignment per step.
  task automatic issue_req(func_t f, logic [63:0] h, logic [63:0] d);
    while ($urandom_range(99) < req_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.func    <= f;
    req_ch.handle  <= h;
    req_ch.data_in <= d;
    do @(posedge clk); while (!req_ch.ready);
    slot_map_step(f, h, d);
  endtask

  // Drop valid and hold until every owed response has been taken.
  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Write gen_seed; only called with the design idle.
  task automatic write_seed(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_reg   = v;
  endtask

  task automatic set_idling(int unsigned req_pct, int unsigned rsp_pct);
    req_gap_pct = req_pct;
    rsp_gap_pct = rsp_pct;
  endtask

  // One random request. alloc_pct sets the share of allocations; the rest are
  // split between live-handle traffic, stale or freed handles and pure noise.
  task automatic churn_item(int unsigned alloc_pct);
    int unsigned r;
    int unsigned s;
    int unsigned i;
    logic [63:0] h;
    logic [63:0] d;
    func_t       f;
    bit          got;
    d = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < alloc_pct) begin
      // handle and data are don't-care on allocate; keep them noisy
      issue_req(FUNC_ALLOC, {$urandom, $urandom}, d);
    end else begin
      s   = $urandom_range(9);
      got = pick_live(h);
      if (s <= 2 && got) begin
        issue_req(FUNC_FREE, h, d);
      end else if (s <= 4 && got) begin
        issue_req(FUNC_GET, h, d);
      end else if (s <= 6 && got) begin
        issue_req(FUNC_SET, h, d);
      end else if (s <= 8 && issued != 0) begin
        // Issued index: off-by-one generation, or the current one (slot may be free)
        i = $urandom_range(issued - 1);
        if (s == 7)
          h = make_handle($urandom_range(1) ? slot_gen[i] + 32'd1 : slot_gen[i] - 32'd1, i);
        else
          h = make_handle(slot_gen[i], i);
        f = func_t'($urandom_range(3, 1));
        issue_req(f, h, d);
      end else begin
        f = func_t'($urandom_range(3, 1));
        issue_req(f, {$urandom, $urandom}, d);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked beats: data extremes, every function, generation wrap, double
  // free, stale handles, unissued and out-of-range indexes, LIFO reuse.
  task automatic test_basic_ops();
    logic [63:0] h_a;
    logic [63:0] h_b;
    set_idling(0, 0);
    write_seed(32'hffff_ffff);
    issue_req(FUNC_ALLOC, '1, '1);
    h_a = last_rsp.handle_out;
    issue_req(FUNC_GET, h_a, '1);                      // cleared on allocate
    issue_req(FUNC_SET, h_a, '1);
    issue_req(FUNC_GET, h_a, '0);
    issue_req(FUNC_ALLOC, '0, '0);
    h_b = last_rsp.handle_out;
    issue_req(FUNC_SET, h_b, 64'h0123_4567_89ab_cdef);
    issue_req(FUNC_GET, h_b, '0);
    issue_req(FUNC_FREE, h_a, '0);                     // generation wraps to zero
    issue_req(FUNC_GET, h_a, '0);                      // stale
    issue_req(FUNC_FREE, h_a, '0);                     // double free
    issue_req(FUNC_SET, h_a, '1);
    issue_req(FUNC_GET, make_handle(32'h0, 0), '0);    // generation right, slot free
    issue_req(FUNC_GET, make_handle(32'h0, issued), '0);
    issue_req(FUNC_SET, make_handle('1, 32'hffff_ffff), '1);
    issue_req(FUNC_GET, '0, '0);
    issue_req(FUNC_FREE, '1, '0);
    issue_req(FUNC_ALLOC, '0, '1);                     // reuse slot 0
    h_a = last_rsp.handle_out;
    issue_req(FUNC_GET, h_a, '0);
    issue_req(FUNC_FREE, h_b, '0);
    issue_req(FUNC_FREE, h_a, '0);
    issue_req(FUNC_ALLOC, '0, '0);                     // last freed comes back first
    issue_req(FUNC_ALLOC, '0, '0);
    wait_drain();
  endtask

  // Fill the table through all page boundaries with a new seed per stretch,
  // then keep allocating against a full table.
  task automatic test_fill_table();
    set_idling(26, 49);
    write_seed($urandom);
    while (issued < 300) churn_item(95);
    wait_drain();
    set_idling(49, 26);
    write_seed(32'h0);
    while (issued < 600) churn_item(95);
    wait_drain();
    set_idling(0, 0);
    write_seed($urandom);
    while (!(issued == ENTRIES && free_top == ENTRIES)) churn_item(95);
    repeat (12) churn_item(95);
    wait_drain();
  endtask

  // Balanced allocate/free traffic on a full table, in each idling mode.
  task automatic test_churn();
    set_idling(26, 49);
    repeat (40) churn_item(25);
    set_idling(49, 26);
    repeat (40) churn_item(25);
    set_idling(0, 0);
    repeat (40) churn_item(25);
    wait_drain();
  endtask

  // Hold the response side off for a long stretch while requests keep coming,
  // so the design backs up and stalls its input.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_left <= 300;
    repeat (40) churn_item(50);
    wait_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Drive ready: count down a hold-off when one is pending, else random stalls.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_gap_pct);
      end
    end
  end

  // Compare every accepted response beat with the oldest owed one.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        note_mismatch("unexpected response", rsp_ch.handle_out, '0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_ch.ok !== want.ok)
          note_mismatch("ok", 64'(rsp_ch.ok), 64'(want.ok));
        if (rsp_ch.handle_out !== want.handle_out)
          note_mismatch("handle_out", rsp_ch.handle_out, want.handle_out);
        if (rsp_ch.data_out !== want.data_out)
          note_mismatch("data_out", rsp_ch.data_out, want.data_out);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst            <= 1'b1;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    req_ch.valid   <= 1'b0;
    req_ch.func    <= FUNC_ALLOC;
    req_ch.handle  <= '0;
    req_ch.data_in <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_fill_table();
    test_churn();
    test_backpressure();

    // Let any stray response show up before the verdict
    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
design/ght_pkg.sv
design/ght_if.sv
design/ght_slot_mem.sv
design/ght_exec.sv
design/generational_handle_table.sv
bench/testbench.sv
